@@ hdl/slbm_pkg.sv @@
// Shared types, constants and codes for the segment latency budget monitor.
`default_nettype none

package slbm_pkg;

  localparam int unsigned TRACKED_SEGMENTS = 32;
  localparam int unsigned IDX_W = (TRACKED_SEGMENTS > 1) ? $clog2(TRACKED_SEGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(TRACKED_SEGMENTS + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  localparam int unsigned ACT_W      = 3;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned BUD_W      = 31;
  localparam int unsigned STAGE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 64;

  typedef logic [IDX_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [BUD_W-1:0] budget_t;
  typedef logic [TS_W-1:0]  stamp_t;

  localparam budget_t BUD_MAX = {BUD_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_LOCK        = 3'd0,
    ACT_ASR_START   = 3'd1,
    ACT_ASR_END     = 3'd2,
    ACT_LLM_START   = 3'd3,
    ACT_FIRST_TOKEN = 3'd4,
    ACT_TTS_START   = 3'd5,
    ACT_FIRST_AUDIO = 3'd6
  } action_e;

  typedef enum logic [STAGE_W-1:0] {
    STAGE_ASR = 2'd0,
    STAGE_LLM = 2'd1,
    STAGE_TTS = 2'd2,
    STAGE_E2E = 2'd3
  } stage_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ASR_BUDGET      = 3'd0,
    REG_LLM_BUDGET      = 3'd1,
    REG_TTS_BUDGET      = 3'd2,
    REG_E2E_NORMAL      = 3'd3,
    REG_E2E_THROTTLE    = 3'd4,
    REG_THROTTLE_MODE   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC,
    ST_CHECK,
    ST_EMIT0,
    ST_EMIT1
  } state_e;

  typedef struct packed {
    logic capture;
    logic match;
    logic exec;
    logic read;
    logic check;
    logic load0;
    logic load1;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             hit;
    logic             fire0;
    logic             fire1;
    logic             out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/segment_latency_budget_monitor.sv @@
// Top level of the segment latency budget monitor.
// Usage:
//   Event beats enter on s_axis: tuser carries the event kind (lock, stage
//   start, stage end), tdata the segment id and a 64-bit stamp. Over-budget
//   warnings leave on m_axis, one beat per warning, at most two per event
//   (stage warning first, end-to-end second); tlast marks the final warning
//   of an event. Budgets and the throttle select are written over the cfg
//   port (index 0..5), one write per cycle, always ready.
// Sequencing:
//   One event is handled at a time. A lock, start or unknown-segment event
//   passes accept, match and execute; an end event goes on to the check
//   and the emit steps, where a warning waits until the output register
//   is free. The controller sequence sets this: id match over all 32 slots,
//   one registered read of the stamp memories, the check, one emit step per
//   possible warning.
// Reset:
//   Clear entry count, ring head and control state; budgets return to defaults.
// Stalls:
//   A pending warning holds the controller only when a new warning needs
//   the output register; other events keep flowing.
`default_nettype none

module segment_latency_budget_monitor (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // event channel
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] segment id, [95:32] event stamp
  input  wire  [slbm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [2:0] action
  input  wire  [slbm_pkg::ACT_W-1:0]           s_axis_tuser,
  // warning channel
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [30:0] measured latency, [61:31] exceeded budget, [63:62] zero
  output logic [slbm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [1:0] stage
  output logic [slbm_pkg::STAGE_W-1:0]         m_axis_tuser,
  output logic                                 m_axis_tlast,
  // configuration write channel
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [slbm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [slbm_pkg::BUD_W-1:0]           cfg_data_i
);
  import slbm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  budget_t    out_actual, out_budget;

  // Config registers never stall: every write beat lands the same cycle.
  assign cfg_ready_o = 1'b1;

  slbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slbm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_action_i  (s_axis_tuser),
    .in_id_i      (s_axis_tdata[ID_W-1:0]),
    .in_ts_i      (s_axis_tdata[ID_W+TS_W-1:ID_W]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_stage_o  (m_axis_tuser),
    .out_actual_o (out_actual),
    .out_budget_o (out_budget),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the warning payload, pad bits tied low.
  assign m_axis_tdata = {{(OUT_DATA_W - 2 * BUD_W){1'b0}}, out_budget, out_actual};

endmodule

`default_nettype wire

@@ hdl/slbm_ctrl.sv @@
// Sequencing state machine: accept, match, execute, check and emit warnings.
`default_nettype none

module slbm_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  slbm_pkg::dp_status_t status_i,
  output slbm_pkg::dp_cmd_t    cmd_o
);
  import slbm_pkg::*;

  state_e state_q, state_d;
  logic   is_end;

  assign is_end = (status_i.action == ACT_ASR_END) ||
                  (status_i.action == ACT_FIRST_TOKEN) ||
                  (status_i.action == ACT_FIRST_AUDIO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (is_end && status_i.hit) begin
          cmd_o.read = 1'b1;
          state_d    = ST_CHECK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_EMIT0;
      end
      ST_EMIT0: begin
        // hold until the output register frees up
        if (!status_i.fire0) begin
          state_d = ST_EMIT1;
        end else if (status_i.out_free) begin
          cmd_o.load0 = 1'b1;
          state_d     = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (!status_i.fire1) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.load1 = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/slbm_datapath.sv @@
// Segment table, stamp memories, latency checks, config registers and output register.
`default_nettype none

module slbm_datapath (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  slbm_pkg::dp_cmd_t               cmd_i,
  output slbm_pkg::dp_status_t            status_o,
  input  wire [slbm_pkg::ACT_W-1:0]       in_action_i,
  input  wire [slbm_pkg::ID_W-1:0]        in_id_i,
  input  wire [slbm_pkg::TS_W-1:0]        in_ts_i,
  input  wire                             cfg_we_i,
  input  wire [slbm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [slbm_pkg::BUD_W-1:0]       cfg_data_i,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output logic [slbm_pkg::STAGE_W-1:0]    out_stage_o,
  output logic [slbm_pkg::BUD_W-1:0]      out_actual_o,
  output logic [slbm_pkg::BUD_W-1:0]      out_budget_o,
  output logic                            out_last_o
);
  import slbm_pkg::*;

  // configuration
  budget_t asr_bud_q, llm_bud_q, tts_bud_q, e2e_norm_q, e2e_thr_q;
  logic    throttle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asr_bud_q  <= budget_t'(300);
      llm_bud_q  <= budget_t'(300);
      tts_bud_q  <= budget_t'(200);
      e2e_norm_q <= budget_t'(800);
      e2e_thr_q  <= budget_t'(1200);
      throttle_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ASR_BUDGET:    asr_bud_q  <= cfg_data_i;
        REG_LLM_BUDGET:    llm_bud_q  <= cfg_data_i;
        REG_TTS_BUDGET:    tts_bud_q  <= cfg_data_i;
        REG_E2E_NORMAL:    e2e_norm_q <= cfg_data_i;
        REG_E2E_THROTTLE:  e2e_thr_q  <= cfg_data_i;
        REG_THROTTLE_MODE: throttle_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // captured item
  logic [ACT_W-1:0] action_q;
  logic [ID_W-1:0]  id_q;
  stamp_t           ts_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_action_i;
      id_q     <= in_id_i;
      ts_q     <= in_ts_i;
    end
  end

  // table as a ring: logical entry i sits at physical slot (head + i) mod depth
  function automatic cnt_t rel_idx(slot_t p, slot_t h);
    sum_t r;
    if (p >= h) begin
      r = sum_t'(p) - sum_t'(h);
    end else begin
      r = sum_t'(p) + sum_t'(TRACKED_SEGMENTS) - sum_t'(h);
    end
    return cnt_t'(r);
  endfunction

  logic [ID_W-1:0] ids_q [TRACKED_SEGMENTS];
  slot_t           head_q;
  cnt_t            count_q;
  logic            hit_q;
  slot_t           slot_q;

  logic [TRACKED_SEGMENTS-1:0] match_vec, match_hi, pick_vec;
  slot_t                       match_slot;

  always_comb begin
    match_slot = '0;
    for (int p = 0; p < TRACKED_SEGMENTS; p++) begin
      match_vec[p] = (ids_q[p] == id_q) && (rel_idx(slot_t'(p), head_q) < count_q);
      match_hi[p]  = match_vec[p] && (slot_t'(p) >= head_q);
    end
    // oldest first: slots from head upward come before the wrapped ones
    pick_vec = (|match_hi) ? match_hi : match_vec;
    for (int p = TRACKED_SEGMENTS - 1; p >= 0; p--) begin
      if (pick_vec[p]) begin
        match_slot = slot_t'(p);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.match) begin
      hit_q <= |match_vec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      slot_q <= match_slot;
    end
  end

  // placement of a new entry
  logic  full;
  sum_t  tail_sum;
  slot_t tail_slot, head_next, wr_slot;
  logic  new_entry;

  assign full      = (count_q == cnt_t'(TRACKED_SEGMENTS));
  assign tail_sum  = sum_t'(head_q) + sum_t'(count_q);
  assign tail_slot = (tail_sum >= sum_t'(TRACKED_SEGMENTS)) ?
                     slot_t'(tail_sum - sum_t'(TRACKED_SEGMENTS)) : slot_t'(tail_sum);
  assign head_next = (head_q == slot_t'(TRACKED_SEGMENTS - 1)) ? '0 : head_q + slot_t'(1);
  assign new_entry = cmd_i.exec && (action_q == ACT_LOCK) && !hit_q;
  assign wr_slot   = new_entry ? (full ? head_q : tail_slot) : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (new_entry) begin
      if (full) begin
        head_q <= head_next;
      end else begin
        count_q <= count_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_entry) begin
      ids_q[wr_slot] <= id_q;
    end
  end

  // stamp memories, one write and one registered read port each
  logic   we_lock, we_asr, we_llm, we_tts;
  stamp_t start_wdata;

  assign we_lock = cmd_i.exec && (action_q == ACT_LOCK);
  assign we_asr  = new_entry || (cmd_i.exec && hit_q && (action_q == ACT_ASR_START));
  assign we_llm  = new_entry || (cmd_i.exec && hit_q && (action_q == ACT_LLM_START));
  assign we_tts  = new_entry || (cmd_i.exec && hit_q && (action_q == ACT_TTS_START));
  assign start_wdata = (action_q == ACT_LOCK) ? '0 : ts_q;

  stamp_t lock_mem [TRACKED_SEGMENTS];
  stamp_t asr_mem  [TRACKED_SEGMENTS];
  stamp_t llm_mem  [TRACKED_SEGMENTS];
  stamp_t tts_mem  [TRACKED_SEGMENTS];
  stamp_t lock_rd_q, asr_rd_q, llm_rd_q, tts_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_lock) begin
      lock_mem[wr_slot] <= ts_q;
    end
    if (cmd_i.read) begin
      lock_rd_q <= lock_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_asr) begin
      asr_mem[wr_slot] <= start_wdata;
    end
    if (cmd_i.read) begin
      asr_rd_q <= asr_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_llm) begin
      llm_mem[wr_slot] <= start_wdata;
    end
    if (cmd_i.read) begin
      llm_rd_q <= llm_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_tts) begin
      tts_mem[wr_slot] <= start_wdata;
    end
    if (cmd_i.read) begin
      tts_rd_q <= tts_mem[slot_q];
    end
  end

  // latency checks
  stamp_t  start_sel, diff0, diff1;
  budget_t bud0, bud1;
  stage_e  stage0;
  logic    fire0_d, fire1_d;

  always_comb begin
    case (action_q)
      ACT_ASR_END: begin
        start_sel = asr_rd_q;
        bud0      = asr_bud_q;
        stage0    = STAGE_ASR;
      end
      ACT_FIRST_TOKEN: begin
        start_sel = llm_rd_q;
        bud0      = llm_bud_q;
        stage0    = STAGE_LLM;
      end
      default: begin
        start_sel = tts_rd_q;
        bud0      = tts_bud_q;
        stage0    = STAGE_TTS;
      end
    endcase
    bud1    = throttle_q ? e2e_thr_q : e2e_norm_q;
    diff0   = ts_q - start_sel;
    diff1   = ts_q - lock_rd_q;
    fire0_d = (start_sel != '0) && (diff0 > stamp_t'(bud0));
    fire1_d = (action_q == ACT_FIRST_AUDIO) && (lock_rd_q != '0) &&
              (diff1 > stamp_t'(bud1));
  end

  logic    fire0_q, fire1_q;
  stage_e  w0_stage_q;
  budget_t w0_actual_q, w0_budget_q, w1_actual_q, w1_budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire0_q <= 1'b0;
      fire1_q <= 1'b0;
    end else if (cmd_i.check) begin
      fire0_q <= fire0_d;
      fire1_q <= fire1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      w0_stage_q  <= stage0;
      w0_actual_q <= (diff0 > stamp_t'(BUD_MAX)) ? BUD_MAX : diff0[BUD_W-1:0];
      w0_budget_q <= bud0;
      w1_actual_q <= (diff1 > stamp_t'(BUD_MAX)) ? BUD_MAX : diff1[BUD_W-1:0];
      w1_budget_q <= bud1;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load0 || cmd_i.load1) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load0) begin
      out_stage_o  <= w0_stage_q;
      out_actual_o <= w0_actual_q;
      out_budget_o <= w0_budget_q;
      out_last_o   <= !fire1_q;
    end else if (cmd_i.load1) begin
      out_stage_o  <= STAGE_E2E;
      out_actual_o <= w1_actual_q;
      out_budget_o <= w1_budget_q;
      out_last_o   <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.action   = action_q;
  assign status_o.hit      = hit_q;
  assign status_o.fire0    = fire0_q;
  assign status_o.fire1    = fire1_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(TRACKED_SEGMENTS))
    else $error("entry count above table depth");

  a_head_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != '0) |-> full)
    else $error("ring head moved before table filled");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && hit_q) |-> (rel_idx(slot_q, head_q) < count_q))
    else $error("matched slot outside live entries");

  a_load_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load0 || cmd_i.load1) |-> (!out_valid_q || out_ready_i))
    else $error("warning loaded over a pending beat");
`endif

endmodule

`default_nettype wire

@@ tb/segment_latency_budget_monitor_check.sv @@
`timescale 1ns / 1ps
// Warning predictor and scoreboard for the segment latency budget monitor.
module segment_latency_budget_monitor_check
  import slbm_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     ev_valid_i,
  input  wire                     ev_ready_i,
  input  wire [IN_DATA_W-1:0]     ev_data_i,     // [31:0] segment id, [95:32] event stamp
  input  wire [ACT_W-1:0]         ev_kind_i,     // [2:0] action
  input  wire                     warn_valid_i,
  input  wire                     warn_ready_i,
  input  wire [OUT_DATA_W-1:0]    warn_data_i,   // [30:0] actual, [61:31] budget, [63:62] zero
  input  wire [STAGE_W-1:0]       warn_stage_i,  // [1:0] stage
  input  wire                     warn_last_i,
  input  wire                     cfg_valid_i,
  input  wire                     cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [BUD_W-1:0]         cfg_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             open_count_o,
  output int unsigned             warn_count_o,
  output int unsigned             evict_count_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    stage_e  stage;
    budget_t actual;
    budget_t budget;
    logic    last;
  } warning_t;

  // Shadow of the segment table, oldest entry at index 0
  logic [ID_W-1:0] seg_id   [TRACKED_SEGMENTS];
  stamp_t          lock_at  [TRACKED_SEGMENTS];
  stamp_t          asr_at   [TRACKED_SEGMENTS];
  stamp_t          llm_at   [TRACKED_SEGMENTS];
  stamp_t          tts_at   [TRACKED_SEGMENTS];
  int unsigned     seg_count;

  budget_t asr_limit, llm_limit, tts_limit, e2e_normal_limit, e2e_throttle_limit;
  logic    throttled;

  warning_t    pending_warnings [$];
  warning_t    exp_w;
  int unsigned fails, warns, evictions;

  function automatic int find_segment(logic [ID_W-1:0] id);
    for (int i = 0; i < seg_count; i++) begin
      if (seg_id[i] == id) return i;
    end
    return -1;
  endfunction

  // A check fires only for a set start stamp and a full 64-bit overrun
  function automatic bit overrun(stamp_t start, stamp_t stamp, budget_t limit);
    stamp_t latency;
    latency = stamp - start;
    return (start != '0) && (latency > limit);
  endfunction

  function automatic warning_t make_warning(stage_e stage, stamp_t start, stamp_t stamp,
                                            budget_t limit);
    warning_t w;
    stamp_t   latency;
    latency  = stamp - start;
    w.stage  = stage;
    w.actual = (latency > stamp_t'(BUD_MAX)) ? BUD_MAX : latency[BUD_W-1:0];
    w.budget = limit;
    w.last   = 1'b0;
    return w;
  endfunction

  task automatic take_event(logic [ACT_W-1:0] kind, logic [ID_W-1:0] id, stamp_t stamp);
    int       slot;
    int       n;
    warning_t found [2];
    budget_t  e2e_limit;
    n         = 0;
    e2e_limit = throttled ? e2e_throttle_limit : e2e_normal_limit;
    slot      = find_segment(id);
    if (kind == ACT_LOCK) begin
      if (slot >= 0) begin
        lock_at[slot] = stamp;
      end else begin
        if (seg_count == TRACKED_SEGMENTS) begin
          // table full: drop the oldest and shift the rest down
          for (int i = 0; i + 1 < TRACKED_SEGMENTS; i++) begin
            seg_id[i]  = seg_id[i+1];
            lock_at[i] = lock_at[i+1];
            asr_at[i]  = asr_at[i+1];
            llm_at[i]  = llm_at[i+1];
            tts_at[i]  = tts_at[i+1];
          end
          slot = TRACKED_SEGMENTS - 1;
          evictions++;
        end else begin
          slot = seg_count;
          seg_count++;
        end
        seg_id[slot]  = id;
        lock_at[slot] = stamp;
        asr_at[slot]  = '0;
        llm_at[slot]  = '0;
        tts_at[slot]  = '0;
      end
      return;
    end
    if (slot < 0) return;
    case (kind)
      ACT_ASR_START: asr_at[slot] = stamp;
      ACT_LLM_START: llm_at[slot] = stamp;
      ACT_TTS_START: tts_at[slot] = stamp;
      ACT_ASR_END: begin
        if (overrun(asr_at[slot], stamp, asr_limit)) begin
          found[n] = make_warning(STAGE_ASR, asr_at[slot], stamp, asr_limit);
          n++;
        end
      end
      ACT_FIRST_TOKEN: begin
        if (overrun(llm_at[slot], stamp, llm_limit)) begin
          found[n] = make_warning(STAGE_LLM, llm_at[slot], stamp, llm_limit);
          n++;
        end
      end
      ACT_FIRST_AUDIO: begin
        // stage warning goes out ahead of the end-to-end one
        if (overrun(tts_at[slot], stamp, tts_limit)) begin
          found[n] = make_warning(STAGE_TTS, tts_at[slot], stamp, tts_limit);
          n++;
        end
        if (overrun(lock_at[slot], stamp, e2e_limit)) begin
          found[n] = make_warning(STAGE_E2E, lock_at[slot], stamp, e2e_limit);
          n++;
        end
      end
      default: ;  // unused event kind is dropped
    endcase
    for (int k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      pending_warnings.push_back(found[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count          = 0;
      asr_limit          = 31'd300;
      llm_limit          = 31'd300;
      tts_limit          = 31'd200;
      e2e_normal_limit   = 31'd800;
      e2e_throttle_limit = 31'd1200;
      throttled          = 1'b0;
      pending_warnings.delete();
      fails              = 0;
      warns              = 0;
      evictions          = 0;
      fail_count_o  <= 0;
      open_count_o  <= 0;
      warn_count_o  <= 0;
      evict_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ASR_BUDGET:    asr_limit          = cfg_data_i;
          REG_LLM_BUDGET:    llm_limit          = cfg_data_i;
          REG_TTS_BUDGET:    tts_limit          = cfg_data_i;
          REG_E2E_NORMAL:    e2e_normal_limit   = cfg_data_i;
          REG_E2E_THROTTLE:  e2e_throttle_limit = cfg_data_i;
          REG_THROTTLE_MODE: throttled          = cfg_data_i[0];
          default: ;  // writes past the last register are dropped
        endcase
      end

      if (ev_valid_i && ev_ready_i) begin
        take_event(ev_kind_i, ev_data_i[ID_W-1:0], ev_data_i[ID_W +: TS_W]);
      end

      if (warn_valid_i && warn_ready_i) begin
        warns++;
        if (pending_warnings.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: unexpected warning stage %0d actual %0d budget %0d last %0b",
                     $realtime, warn_stage_i, warn_data_i[BUD_W-1:0],
                     warn_data_i[BUD_W +: BUD_W], warn_last_i);
          end
        end else begin
          exp_w = pending_warnings.pop_front();
          if (warn_stage_i !== exp_w.stage || warn_data_i[BUD_W-1:0] !== exp_w.actual ||
              warn_data_i[BUD_W +: BUD_W] !== exp_w.budget ||
              warn_data_i[OUT_DATA_W-1:2*BUD_W] !== '0 || warn_last_i !== exp_w.last) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: warning mismatch, expected stage %0d actual %0d budget %0d last %0b",
                       $realtime, exp_w.stage, exp_w.actual, exp_w.budget, exp_w.last);
              $display("%0t:   got stage %0d actual %0d budget %0d last %0b pad %0h",
                       $realtime, warn_stage_i, warn_data_i[BUD_W-1:0],
                       warn_data_i[BUD_W +: BUD_W], warn_last_i,
                       warn_data_i[OUT_DATA_W-1:2*BUD_W]);
            end
          end
        end
      end

      fail_count_o  <= fails;
      open_count_o  <= pending_warnings.size();
      warn_count_o  <= warns;
      evict_count_o <= evictions;
    end
  end

endmodule

@@ tb/segment_latency_budget_monitor_test.sv @@
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the segment latency budget monitor.
module segment_latency_budget_monitor_test;
  import slbm_pkg::*;

  // Cycles without any accepted beat before the run is declared hung
  localparam int unsigned IDLE_LIMIT       = 3000;
  // Cycles to let a silent end event finish before touching the registers
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned BUDGET_SETTINGS  = 6;
  localparam int unsigned EVENTS_PER_PHASE = 175;
  // More ids than table slots, so flows keep pushing entries out
  localparam int unsigned POOL_SIZE        = 44;

  // Codes past the defined ranges; the block must ignore them
  localparam logic [ACT_W-1:0]     ACT_SPARE    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,     // never stall
    RX_MOSTLY,   // ready three beats in four
    RX_SPARSE,   // ready one beat in four
    RX_PULSED    // fixed on/off pattern
  } rx_mode_e;

  logic clk;
  logic rst_n = 1'b0;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] segment id, [95:32] event stamp
  logic [ACT_W-1:0]      s_tuser  = '0;   // [2:0] action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [30:0] latency, [61:31] budget, [63:62] zero
  logic [STAGE_W-1:0]    m_tuser;         // [1:0] stage
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BUD_W-1:0]      cfg_data  = '0;

  int unsigned fail_count, open_count, warn_count, evict_count;

  // Stimulus bookkeeping
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  budget_t         limit_copy [5];
  logic            throttle_copy;
  int unsigned     burst_left   = 0;
  int unsigned     events_sent  = 0;
  int unsigned     phase_events = 0;
  int unsigned     idle_cycles  = 0;
  rx_mode_e        rx_mode      = RX_OPEN;
  int unsigned     rx_hold      = 0;

  segment_latency_budget_monitor dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  segment_latency_budget_monitor_check scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .ev_valid_i    (s_tvalid),
    .ev_ready_i    (s_tready),
    .ev_data_i     (s_tdata),
    .ev_kind_i     (s_tuser),
    .warn_valid_i  (m_tvalid),
    .warn_ready_i  (m_tready),
    .warn_data_i   (m_tdata),
    .warn_stage_i  (m_tuser),
    .warn_last_i   (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .open_count_o  (open_count),
    .warn_count_o  (warn_count),
    .evict_count_o (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: hold each stall mode for a random stretch so stalls land on
  // every phase of the block's sequence, with open stretches in between.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_hold <= $urandom_range(16, 96);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_hold % 8) >= 5;
    endcase
  end

  // Watchdog: any accepted beat on any channel resets the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d warnings still owed",
               $realtime, IDLE_LIMIT, open_count);
      $display("segment_latency_budget_monitor_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one event beat; open a new burst with a random gap when the
  // current one is used up. Valid is only lowered when a gap follows.
  task automatic send_event(logic [ACT_W-1:0] kind, logic [ID_W-1:0] id, stamp_t stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, id};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    if (kind != ACT_SPARE) begin
      events_sent++;
      phase_events++;
    end
  endtask

  // Hold valid high across back-to-back writes; the caller drops it after
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, budget_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx <= REG_E2E_THROTTLE) limit_copy[idx] = value;
    else if (idx == REG_THROTTLE_MODE) throttle_copy = value[0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop sending and wait until every owed warning is out and a silent
  // end event has had time to leave the pipeline.
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (open_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pick an end stamp that lands around a budget, far past it, or before
  // the start so the difference wraps.
  function automatic stamp_t stamp_near_budget(stamp_t from, budget_t limit);
    stamp_t stamp;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      stamp = from + limit;
      stamp = stamp + $urandom_range(0, 2);
      stamp = stamp - 1;
    end else if (pick < 75) begin
      stamp = from + $urandom_range(0, 2 * limit);
    end else if (pick < 90) begin
      stamp = from + {$urandom, $urandom};
    end else begin
      stamp = from - $urandom_range(1, 1000);
    end
    return stamp;
  endfunction

  // One segment through lock, the three stages and first audio, with a step
  // skipped now and then and the odd unset start stamp.
  task automatic run_flow();
    logic [ID_W-1:0] id;
    stamp_t          stamp;
    stamp_t          lock_stamp;
    stamp_t          sent;
    action_e         kind;
    int unsigned     pick;
    id         = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    stamp      = '0;
    lock_stamp = '0;
    for (int k = ACT_LOCK; k <= ACT_FIRST_AUDIO; k++) begin
      kind = action_e'(k);
      sent = stamp;
      case (kind)
        ACT_LOCK: begin
          pick = $urandom_range(0, 99);
          if (pick < 80)      stamp = {24'd0, 8'($urandom), $urandom};
          else if (pick < 90) stamp = '1 - $urandom_range(0, 2000);
          else                stamp = {$urandom, $urandom};
          lock_stamp = stamp;
          sent       = ($urandom_range(0, 29) == 0) ? '0 : stamp;
        end
        ACT_ASR_START, ACT_LLM_START, ACT_TTS_START: begin
          stamp = stamp + $urandom_range(0, 40);
          sent  = ($urandom_range(0, 19) == 0) ? '0 : stamp;
        end
        ACT_ASR_END: begin
          stamp = stamp_near_budget(stamp, limit_copy[REG_ASR_BUDGET]);
          sent  = stamp;
        end
        ACT_FIRST_TOKEN: begin
          stamp = stamp_near_budget(stamp, limit_copy[REG_LLM_BUDGET]);
          sent  = stamp;
        end
        default: begin
          // first audio: aim at either the stage or the end-to-end budget
          if ($urandom_range(0, 1) == 0) begin
            stamp = stamp_near_budget(stamp, limit_copy[REG_TTS_BUDGET]);
          end else begin
            stamp = stamp_near_budget(lock_stamp, throttle_copy ?
                                      limit_copy[REG_E2E_THROTTLE] :
                                      limit_copy[REG_E2E_NORMAL]);
          end
          sent = stamp;
        end
      endcase
      if ($urandom_range(0, 99) < 88) send_event(kind, id, sent);
    end
  endtask

  // Write every register; the first two settings are the extremes.
  task automatic program_budgets(int unsigned setting);
    budget_t                value;
    logic [CFG_IDX_W-1:0]   idx;
    for (int r = REG_ASR_BUDGET; r <= REG_E2E_THROTTLE; r++) begin
      idx = CFG_IDX_W'(r);
      case (setting)
        0: value = '0;
        1: value = BUD_MAX;
        default: begin
          case ($urandom_range(0, 3))
            0:       value = budget_t'($urandom_range(0, 50));
            1:       value = budget_t'($urandom_range(100, 2000));
            2:       value = budget_t'($urandom);
            default: value = budget_t'(BUD_MAX - $urandom_range(0, 1000));
          endcase
        end
      endcase
      write_reg(idx, value);
    end
    // Upper bits of the mode write are noise and must be masked off
    value    = budget_t'($urandom);
    value[0] = (setting == 0) ? 1'b1 : (setting == 1) ? 1'b0 : 1'($urandom);
    write_reg(REG_THROTTLE_MODE, value);
    write_reg(REG_SPARE_LO, budget_t'($urandom));
    write_reg(REG_SPARE_HI, budget_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at the reset budgets (asr 300, llm 300, tts 200, e2e 800)
    send_event(ACT_ASR_END,     32'h1234_5678, 64'd1000);  // unknown segment
    send_event(ACT_LOCK,        '0,            64'd1000);
    send_event(ACT_FIRST_AUDIO, '0,            64'd1801);  // e2e just over, tts unset
    send_event(ACT_ASR_START,   '0,            64'd2000);
    send_event(ACT_ASR_END,     '0,            64'd2300);  // exactly on budget
    send_event(ACT_ASR_END,     '0,            64'd2301);  // one over
    send_event(ACT_LLM_START,   '0,            64'd3000);
    send_event(ACT_FIRST_TOKEN, '0,            64'd2999);  // earlier than start, saturates
    send_event(ACT_TTS_START,   '0,            64'd4000);
    send_event(ACT_FIRST_AUDIO, '0,            64'd4201);  // tts and e2e together
    send_event(ACT_LOCK,        '1,            '1);
    send_event(ACT_LOCK,        '1,            64'd5);     // repeated lock rewrites stamp
    send_event(ACT_FIRST_AUDIO, '1,            64'd4);     // e2e wraps
    send_event(ACT_TTS_START,   '1,            '0);        // start left unset
    send_event(ACT_FIRST_AUDIO, '1,            64'd1000);  // tts skipped, e2e fires
    send_event(ACT_SPARE,       '0,            '1);        // unused kind
    send_event(ACT_LOCK,        32'h8000_0001, '0);        // unset lock stamp
    send_event(ACT_FIRST_AUDIO, 32'h8000_0001, 64'h8000_0000_0000_0000);
    send_event(ACT_LOCK,        '0,            64'h1_0000_0000);  // starts survive relock
    send_event(ACT_FIRST_TOKEN, '0,            64'd3300);  // on budget
    send_event(ACT_ASR_START,   32'hDEAD_0000, 64'd5);     // unknown segment
    drain();

    // Random flows plus noise, one budget setting per phase
    for (int setting = 0; setting < BUDGET_SETTINGS; setting++) begin
      program_budgets(setting);
      phase_events = 0;
      while (phase_events < EVENTS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          run_flow();
        end else begin
          send_event(($urandom_range(0, 7) != 0) ? 3'($urandom_range(0, 7)) : ACT_SPARE,
                     ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : $urandom,
                     {$urandom, $urandom});
        end
      end
      drain();
    end

    $display("Covered %0d events over %0d budget settings plus reset values, both e2e modes;",
             events_sent, BUDGET_SETTINGS);
    $display("%0d warning beats checked, %0d table evictions.", warn_count, evict_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("segment_latency_budget_monitor_test OK");
    end else begin
      $display("segment_latency_budget_monitor_test NOT OK");
    end
    $finish;
  end

endmodule
